// ===== rtl/core/mof5_pkg.sv =====
// Shared types and constants for the five-tap median stream filter.
package mof5_pkg;

	localparam int SAMPLE_WIDTH  = 16;
	localparam int TAPS          = 5;
	localparam int HIST_DEPTH    = TAPS - 1;
	localparam int MEDIAN_RANK   = TAPS / 2;
	localparam int MAX_RESULTS   = 3;
	localparam int POS_SATURATE  = 4;
	localparam int POS_FIRST_MED = 4;
	localparam int POS_RAW_LIMIT = 2;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [2:0] pos_t;
	typedef logic [1:0] rcount_t;
	typedef logic [2:0] rank_t;

	// One accepted item with the history and block position it saw.
	typedef struct packed {
		sample_t                      sample;
		logic                         block_end;
		pos_t                         pos;
		logic [HIST_DEPTH-1:0][SAMPLE_WIDTH-1:0] hist;
	} item_t;

	typedef struct packed {
		sample_t value;
		logic    was_filtered;
		logic    run_last;
		logic    block_done;
	} result_t;

	function automatic result_t make_result(sample_t value, logic was_filtered);
		result_t r;
		r.value        = value;
		r.was_filtered = was_filtered;
		r.run_last     = 1'b0;
		r.block_done   = 1'b0;
		return r;
	endfunction

endpackage

// ===== rtl/core/mof5_front.sv =====
// Input stage: sample history, block position and the stage 1 item register.
module mof5_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  mof5_pkg::sample_t   sample,
	input  logic                block_end,
	input  logic                advance,
	output logic                item_valid_s1,
	output mof5_pkg::item_t     item_s1
);

	logic                                                   accept;
	logic [mof5_pkg::HIST_DEPTH-1:0][mof5_pkg::SAMPLE_WIDTH-1:0] hist_q;
	mof5_pkg::pos_t                                         pos_q;

	// hold the new item back while stage 1 cannot hand its own on
	assign sample_stall = item_valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q        <= '0;
			pos_q         <= '0;
			item_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				hist_q[0] <= sample;
				for (int i = 1; i < mof5_pkg::HIST_DEPTH; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
				if (block_end) begin
					pos_q <= '0;
				end else if (pos_q < mof5_pkg::pos_t'(mof5_pkg::POS_SATURATE)) begin
					pos_q <= pos_q + 3'd1;
				end
				item_valid_s1 <= 1'b1;
			end else if (advance) begin
				item_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.sample    <= sample;
			item_s1.block_end <= block_end;
			item_s1.pos       <= pos_q;
			item_s1.hist      <= hist_q;
		end
	end

endmodule

// ===== rtl/core/mof5_select.sv =====
// Five-sample median by rank counting, and the list of results one item causes.
module mof5_select (
	input  mof5_pkg::item_t                                 item,
	output mof5_pkg::result_t [mof5_pkg::MAX_RESULTS-1:0]   slots,
	output mof5_pkg::rcount_t                               count
);

	mof5_pkg::sample_t                w [mof5_pkg::TAPS];
	mof5_pkg::rank_t                  rank [mof5_pkg::TAPS];
	mof5_pkg::sample_t                median;

	always_comb begin
		for (int i = 0; i < mof5_pkg::HIST_DEPTH; i++) begin
			w[i] = $signed(item.hist[i]);
		end
		w[mof5_pkg::TAPS-1] = item.sample;
	end

	// stable rank: ties broken by tap index, so exactly one tap has the middle rank
	always_comb begin
		for (int i = 0; i < mof5_pkg::TAPS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < mof5_pkg::TAPS; j++) begin
				if (j != i && ((w[j] < w[i]) || (w[j] == w[i] && j < i))) begin
					rank[i] = rank[i] + 3'd1;
				end
			end
		end
	end

	always_comb begin
		median = w[0];
		for (int i = 0; i < mof5_pkg::TAPS; i++) begin
			if (rank[i] == mof5_pkg::rank_t'(mof5_pkg::MEDIAN_RANK)) begin
				median = w[i];
			end
		end
	end

	always_comb begin
		slots = '0;
		count = '0;
		if (item.pos < mof5_pkg::pos_t'(mof5_pkg::POS_RAW_LIMIT)) begin
			slots[count] = mof5_pkg::make_result(item.sample, 1'b0);
			count        = count + 2'd1;
		end else if (item.pos >= mof5_pkg::pos_t'(mof5_pkg::POS_FIRST_MED)) begin
			slots[count] = mof5_pkg::make_result(median, 1'b1);
			count        = count + 2'd1;
		end
		// flush the samples still waiting for a centred window
		if (item.block_end) begin
			if (item.pos >= mof5_pkg::pos_t'(mof5_pkg::POS_RAW_LIMIT + 1)) begin
				slots[count] = mof5_pkg::make_result($signed(item.hist[0]), 1'b0);
				count        = count + 2'd1;
			end
			if (item.pos >= mof5_pkg::pos_t'(mof5_pkg::POS_RAW_LIMIT)) begin
				slots[count] = mof5_pkg::make_result(item.sample, 1'b0);
				count        = count + 2'd1;
			end
		end
		if (count != '0) begin
			slots[count - 2'd1].run_last   = 1'b1;
			slots[count - 2'd1].block_done = item.block_end;
		end
	end

endmodule

// ===== rtl/core/mof5_outq.sv =====
// Three-entry result queue; the head entry is the output register.
module mof5_outq (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            push_req,
	input  mof5_pkg::rcount_t                               push_count,
	input  mof5_pkg::result_t [mof5_pkg::MAX_RESULTS-1:0]   push_slots,
	output logic                                            push_ok,
	output logic                                            result_valid,
	input  logic                                            result_stall,
	output mof5_pkg::result_t                               head
);

	mof5_pkg::result_t [mof5_pkg::MAX_RESULTS-1:0] q_q;
	mof5_pkg::result_t [mof5_pkg::MAX_RESULTS-1:0] q_next;
	mof5_pkg::rcount_t                             cnt_q;
	mof5_pkg::rcount_t                             base;
	mof5_pkg::rcount_t                             idx;
	logic                                          pop;
	logic                                          push;
	logic [2:0]                                    fill;

	assign result_valid = cnt_q != '0;
	assign head         = q_q[0];
	assign pop          = result_valid && !result_stall;
	assign base         = cnt_q - mof5_pkg::rcount_t'(pop);
	assign fill         = {1'b0, base} + {1'b0, push_count};
	assign push_ok      = fill <= 3'(mof5_pkg::MAX_RESULTS);
	assign push         = push_req && push_ok;

	always_comb begin
		idx = '0;
		for (int i = 0; i < mof5_pkg::MAX_RESULTS; i++) begin
			if (pop && i < mof5_pkg::MAX_RESULTS - 1) begin
				q_next[i] = q_q[i+1];
			end else begin
				q_next[i] = q_q[i];
			end
		end
		// append behind what stays after the pop
		for (int j = 0; j < mof5_pkg::MAX_RESULTS; j++) begin
			idx = base + mof5_pkg::rcount_t'(j);
			if (push && mof5_pkg::rcount_t'(j) < push_count) begin
				q_next[idx] = push_slots[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= push ? fill[1:0] : base;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_next;
	end

endmodule

// ===== rtl/core/median_of_five_stream_filter_core.sv =====
// Five-tap median filter over blocks of signed samples. An item is taken into an
// input register; its median and edge copies are worked out from that register and
// placed in a three-entry result queue whose head drives the result port. A sample's
// first result passes the input register and the queue head on its way out.
// An item that causes zero or one result leaves room for a new sample in every
// cycle while the result side does not stall; the last sample of a block causes up
// to three results, and since the queue delivers one result a cycle, the input can
// stall at a block end until the queue has room, and longer while results stall.
module median_of_five_stream_filter_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  mof5_pkg::sample_t   sample,
	input  logic                block_end,
	output logic                result_valid,
	input  logic                result_stall,
	output mof5_pkg::sample_t   value,
	output logic                was_filtered,
	output logic                run_last,
	output logic                block_done
);

	mof5_pkg::item_t                                item_s1;
	logic                                           item_valid_s1;
	logic                                           advance;
	logic                                           push_ok;
	mof5_pkg::result_t [mof5_pkg::MAX_RESULTS-1:0]  slots;
	mof5_pkg::rcount_t                              count;
	mof5_pkg::result_t                              head;

	assign advance = item_valid_s1 && push_ok;

	mof5_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.block_end    (block_end),
		.advance      (advance),
		.item_valid_s1(item_valid_s1),
		.item_s1      (item_s1)
	);

	mof5_select u_select (
		.item  (item_s1),
		.slots (slots),
		.count (count)
	);

	mof5_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_req     (item_valid_s1),
		.push_count   (count),
		.push_slots   (slots),
		.push_ok      (push_ok),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.head         (head)
	);

	assign value        = head.value;
	assign was_filtered = head.was_filtered;
	assign run_last     = head.run_last;
	assign block_done   = head.block_done;

endmodule

// ===== rtl/core/mof5_checker.sv =====
// Port-level assertions for the median filter core, and their binding.
module mof5_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input mof5_pkg::sample_t sample,
	input logic              block_end,
	input logic              result_valid,
	input logic              result_stall,
	input mof5_pkg::sample_t value,
	input logic              was_filtered,
	input logic              run_last,
	input logic              block_done
);

	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(sample)
			&& $stable(block_end))
		else $error("stalled input item changed or vanished");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(value)
			&& $stable(was_filtered) && $stable(run_last) && $stable(block_done))
		else $error("stalled result changed or vanished");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && block_done |-> run_last)
		else $error("block end result not marked as last of its item");

	// a median is always followed by the flushed edge copies at a block end
	a_median_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && was_filtered |-> !block_done)
		else $error("filtered result closes a block");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !result_valid)
		else $error("result shown straight out of reset");

endmodule

bind median_of_five_stream_filter_core mof5_checker u_mof5_checker (.*);

// ===== tb/median_of_five_stream_filter_core_tb.sv =====
// Self-checking testbench for the five-tap median stream filter core.
`timescale 1ns / 1ps

module median_of_five_stream_filter_core_tb;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_AT     = 340;
	localparam int HOLD_CYCLES = 80;
	localparam int TAIL_CYCLES = 16;

	typedef struct {
		mof5_pkg::sample_t smp;
		logic              last;
	} stream_item_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	mof5_pkg::sample_t sample       = '0;
	logic              block_end    = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	mof5_pkg::sample_t value;
	logic              was_filtered;
	logic              run_last;
	logic              block_done;

	stream_item_t      sample_queue[$];
	mof5_pkg::result_t expected_out[$];

	// filter state as the block should hold it
	mof5_pkg::sample_t recent_samples[mof5_pkg::HIST_DEPTH];
	mof5_pkg::pos_t    block_pos;

	int tx_idle_pct     = 0;
	int rx_idle_pct     = 0;
	int accepted_items  = 0;
	int mismatch_count  = 0;
	int quiet_cycles    = 0;
	int hold_left       = 0;
	bit hold_done       = 1'b0;

	median_of_five_stream_filter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.block_end    (block_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.was_filtered (was_filtered),
		.run_last     (run_last),
		.block_done   (block_done)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic mof5_pkg::sample_t median_of_five(mof5_pkg::sample_t newest);
		mof5_pkg::sample_t w[mof5_pkg::TAPS];
		mof5_pkg::sample_t t;
		int j;
		for (int i = 0; i < mof5_pkg::HIST_DEPTH; i++)
			w[i] = recent_samples[i];
		w[mof5_pkg::TAPS-1] = newest;
		for (int i = 1; i < mof5_pkg::TAPS; i++) begin
			t = w[i];
			j = i - 1;
			while (j >= 0 && w[j] > t) begin
				w[j+1] = w[j];
				j--;
			end
			w[j+1] = t;
		end
		return w[mof5_pkg::MEDIAN_RANK];
	endfunction

	function automatic mof5_pkg::result_t edge_or_median(mof5_pkg::sample_t v, logic filt);
		mof5_pkg::result_t r;
		r.value        = v;
		r.was_filtered = filt;
		r.run_last     = 1'b0;
		r.block_done   = 1'b0;
		return r;
	endfunction

	task automatic filter_sample(mof5_pkg::sample_t s, logic last);
		mof5_pkg::result_t outs[$];
		if (block_pos < mof5_pkg::POS_RAW_LIMIT)
			outs.push_back(edge_or_median(s, 1'b0));
		else if (block_pos >= mof5_pkg::POS_FIRST_MED)
			outs.push_back(edge_or_median(median_of_five(s), 1'b1));
		// flush the samples still waiting for a median
		if (last) begin
			if (block_pos >= 3)
				outs.push_back(edge_or_median(recent_samples[0], 1'b0));
			if (block_pos >= mof5_pkg::POS_RAW_LIMIT)
				outs.push_back(edge_or_median(s, 1'b0));
		end
		if (outs.size() > 0) begin
			outs[outs.size()-1].run_last   = 1'b1;
			outs[outs.size()-1].block_done = last;
		end
		foreach (outs[i])
			expected_out.push_back(outs[i]);
		for (int i = mof5_pkg::HIST_DEPTH - 1; i > 0; i--)
			recent_samples[i] = recent_samples[i-1];
		recent_samples[0] = s;
		if (last)
			block_pos = '0;
		else if (block_pos < mof5_pkg::POS_SATURATE)
			block_pos = block_pos + 1'b1;
	endtask

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		$display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// sender
	always @(posedge clk) begin : drive_samples
		stream_item_t it;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && !sample_stall) begin
				filter_sample(sample, block_end);
				accepted_items++;
			end
			if (sample_valid && sample_stall) begin
				// hold the item on the bus
			end else if (sample_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				it = sample_queue.pop_front();
				sample_valid <= 1'b1;
				sample       <= it.smp;
				block_end    <= it.last;
			end else begin
				sample_valid <= 1'b0;
				sample       <= mof5_pkg::sample_t'($urandom);
				block_end    <= 1'($urandom);
			end
		end
	end

	// receiver, with one long hold-off once the stream is well under way
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (!hold_done && accepted_items >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		mof5_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_out.size() == 0) begin
				report_mismatch("result with nothing expected", value, 0);
			end else begin
				want = expected_out.pop_front();
				if (value !== want.value)
					report_mismatch("value", value, want.value);
				if (was_filtered !== want.was_filtered)
					report_mismatch("was_filtered", was_filtered, want.was_filtered);
				if (run_last !== want.run_last)
					report_mismatch("run_last", run_last, want.run_last);
				if (block_done !== want.block_done)
					report_mismatch("block_done", block_done, want.block_done);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic queue_values(mof5_pkg::sample_t v[$]);
		stream_item_t it;
		foreach (v[i]) begin
			it.smp  = v[i];
			it.last = (i == v.size() - 1);
			sample_queue.push_back(it);
		end
	endtask

	task automatic queue_block(int len);
		int mode;
		mof5_pkg::sample_t base;
		stream_item_t it;
		mode = $urandom_range(3);
		base = mof5_pkg::sample_t'($urandom);
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: it.smp = mof5_pkg::sample_t'($urandom);
				// tight cluster, plenty of ties
				1: it.smp = base + mof5_pkg::sample_t'($urandom_range(8))
					- mof5_pkg::sample_t'(4);
				2: begin
					case ($urandom_range(3))
						0: it.smp = 16'sh7fff;
						1: it.smp = 16'sh8000;
						2: it.smp = '0;
						default: it.smp = '1;
					endcase
				end
				// smooth signal with impulse noise
				default: it.smp = ($urandom_range(9) == 0) ? mof5_pkg::sample_t'($urandom) :
					base + mof5_pkg::sample_t'($urandom_range(3));
			endcase
			it.last = (i == len - 1);
			sample_queue.push_back(it);
		end
	endtask

	// check once everything has settled for the cycle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_queue.size() != 0 || sample_valid || expected_out.size() != 0);
		@(posedge clk);
	endtask

	task automatic random_phase(int n_items, int tx_pct, int rx_pct);
		int sent;
		int pick;
		sent = 0;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 50)
				pick = $urandom_range(6, 1);
			else if (pick < 90)
				pick = $urandom_range(16, 7);
			else
				pick = $urandom_range(40, 17);
			queue_block(pick);
			sent += pick;
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < mof5_pkg::HIST_DEPTH; i++)
			recent_samples[i] = '0;
		block_pos = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// blocks of one to six samples with the extreme values
		tx_idle_pct = 23;
		rx_idle_pct = 82;
		queue_values('{16'sh7fff});
		queue_values('{16'sh8000, 16'sh7fff});
		queue_values('{0, -1, 1});
		queue_values('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
		queue_values('{16'sh8000, 16'sh7fff, 0, 16'sh7fff, 16'sh8000});
		queue_values('{5, 5, -3, 5, -3, 100});
		wait_drained();

		random_phase(130, 23, 82);
		random_phase(130, 82, 23);
		random_phase(120, 0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_out.size() != 0)
			report_mismatch("results never arrived", expected_out.size(), 0);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
